>>> src/cwc_pkg.sv
// Shared types and constants for the clock write-back cache.
// Used by the controller, the datapath and the top level; no dependencies.
package cwc_pkg;

  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int KeyW       = 32;
  localparam int ValW       = 32;
  localparam int CapW       = 5;

  typedef enum logic [1:0] {
    REQ_GET   = 2'd0,
    REQ_SET   = 2'd1,
    REQ_FILL  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LATCH,
    CMD_RESPOND,
    CMD_FILL_SLOT,
    CMD_WRAP,
    CMD_SWEEP_STEP,
    CMD_EVICT,
    CMD_FLUSH_START,
    CMD_FLUSH_EMPTY,
    CMD_FLUSH_EMIT,
    CMD_FLUSH_SKIP
  } cmd_e;

  typedef struct packed {
    logic is_flush;
    logic needs_install;
    logic room;
    logic dirty_none;
    logic sweep_stop;
    logic fmask_bit;
    logic fmask_last;
    logic out_free;
  } status_t;

endpackage

>>> src/cwc_ctrl.sv
// Request sequencer of the clock write-back cache.
// Depends on cwc_pkg; drives the datapath through cmd_e commands.
module cwc_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cwc_pkg::status_t status_i,
  output cwc_pkg::cmd_e    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_LOOK  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = cwc_pkg::CMD_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = cwc_pkg::CMD_LATCH;
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        priority if (status_i.is_flush) begin
          if (!status_i.dirty_none) begin
            cmd_o   = cwc_pkg::CMD_FLUSH_START;
            state_d = ST_FLUSH;
          end else if (status_i.out_free) begin
            cmd_o   = cwc_pkg::CMD_FLUSH_EMPTY;
            state_d = ST_IDLE;
          end
        end else if (!status_i.needs_install) begin
          if (status_i.out_free) begin
            cmd_o   = cwc_pkg::CMD_RESPOND;
            state_d = ST_IDLE;
          end
        end else if (status_i.room) begin
          if (status_i.out_free) begin
            cmd_o   = cwc_pkg::CMD_FILL_SLOT;
            state_d = ST_IDLE;
          end
        end else begin
          cmd_o   = cwc_pkg::CMD_WRAP;
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (!status_i.sweep_stop) begin
          cmd_o = cwc_pkg::CMD_SWEEP_STEP;
        end else if (status_i.out_free) begin
          cmd_o   = cwc_pkg::CMD_EVICT;
          state_d = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (!status_i.fmask_bit) begin
          cmd_o = cwc_pkg::CMD_FLUSH_SKIP;
        end else if (status_i.out_free) begin
          cmd_o = cwc_pkg::CMD_FLUSH_EMIT;
          if (status_i.fmask_last) state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/cwc_datapath.sv
// Entry table, tag compare, clock hand, flush walk and result register.
// Depends on cwc_pkg; acts on commands from cwc_ctrl.
module cwc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  cwc_pkg::cmd_e            cmd_i,
  output cwc_pkg::status_t         status_o,
  input  logic                     cfg_valid_i,
  input  logic [cwc_pkg::CapW-1:0] cfg_data_i,
  input  logic [1:0]               in_type_i,
  input  logic [cwc_pkg::KeyW-1:0] in_key_i,
  input  logic [cwc_pkg::ValW-1:0] in_val_i,
  input  logic                     out_ready_i,
  output logic                     out_valid_o,
  output logic                     out_hit_o,
  output logic [cwc_pkg::ValW-1:0] out_read_o,
  output logic                     out_wb_o,
  output logic [cwc_pkg::KeyW-1:0] out_wb_key_o,
  output logic [cwc_pkg::ValW-1:0] out_wb_val_o,
  output logic                     out_last_o
);

  localparam int N = cwc_pkg::MaxEntries;

  logic [cwc_pkg::KeyW-1:0] keys_q [N];
  logic [cwc_pkg::ValW-1:0] vals_q [N];
  logic [N-1:0]             valid_q, ref_q, dirty_q, fmask_q;
  logic [cwc_pkg::CntW-1:0] filled_q, cap;
  logic [cwc_pkg::CapW-1:0] cap_q;
  logic [cwc_pkg::IdxW-1:0] hand_q, fidx_q, hit_idx, slot;
  logic [1:0]               type_q;
  logic [cwc_pkg::KeyW-1:0] key_q;
  logic [cwc_pkg::ValW-1:0] val_q;
  logic [N-1:0]             in_use, match, live_dirty, fidx_bit;
  logic                     hit, out_free, load, install;
  logic [cwc_pkg::CntW-1:0] hand_inc;

  // Zero acts as one, anything above the table size as the full table.
  always_comb begin
    if (cap_q == '0) begin
      cap = cwc_pkg::CntW'(1);
    end else if (cwc_pkg::CntW'(cap_q) > cwc_pkg::CntW'(N)) begin
      cap = cwc_pkg::CntW'(N);
    end else begin
      cap = cwc_pkg::CntW'(cap_q);
    end
  end

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < N; i++) begin
      in_use[i]     = cwc_pkg::CntW'(i) < cap;
      match[i]      = valid_q[i] && in_use[i] && (keys_q[i] == key_q);
      live_dirty[i] = valid_q[i] && dirty_q[i] && in_use[i];
    end
    for (int i = N - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = cwc_pkg::IdxW'(i);
    end
  end

  assign hit      = |match;
  assign out_free = !out_valid_o || out_ready_i;
  assign fidx_bit = N'(1) << fidx_q;
  assign hand_inc = cwc_pkg::CntW'(hand_q) + cwc_pkg::CntW'(1);
  assign install  = (cmd_i == cwc_pkg::CMD_FILL_SLOT) || (cmd_i == cwc_pkg::CMD_EVICT);
  assign slot     = (cmd_i == cwc_pkg::CMD_EVICT) ? hand_q : filled_q[cwc_pkg::IdxW-1:0];
  assign load     = (cmd_i == cwc_pkg::CMD_RESPOND) || install ||
                    (cmd_i == cwc_pkg::CMD_FLUSH_EMIT) || (cmd_i == cwc_pkg::CMD_FLUSH_EMPTY);

  always_comb begin
    status_o.is_flush      = (type_q == cwc_pkg::REQ_FLUSH);
    status_o.needs_install = !hit && (type_q != cwc_pkg::REQ_GET);
    status_o.room          = filled_q < cap;
    status_o.dirty_none    = (live_dirty == '0);
    status_o.sweep_stop    = !valid_q[hand_q] || !ref_q[hand_q];
    status_o.fmask_bit     = fmask_q[fidx_q];
    status_o.fmask_last    = ((fmask_q & ~fidx_bit) == '0);
    status_o.out_free      = out_free;
  end

  // Payload: request, table contents and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i == cwc_pkg::CMD_LATCH) begin
      type_q <= in_type_i;
      key_q  <= in_key_i;
      val_q  <= in_val_i;
    end
    if (install) begin
      keys_q[slot] <= key_q;
      vals_q[slot] <= val_q;
    end else if (cmd_i == cwc_pkg::CMD_RESPOND && hit && type_q == cwc_pkg::REQ_SET) begin
      vals_q[hit_idx] <= val_q;
    end
    if (load) begin
      out_hit_o    <= 1'b0;
      out_read_o   <= '0;
      out_wb_o     <= 1'b0;
      out_wb_key_o <= '0;
      out_wb_val_o <= '0;
      out_last_o   <= 1'b1;
      unique case (cmd_i)
        cwc_pkg::CMD_RESPOND: begin
          out_hit_o <= hit;
          if (hit && type_q == cwc_pkg::REQ_GET) out_read_o <= vals_q[hit_idx];
        end
        cwc_pkg::CMD_EVICT: begin
          if (valid_q[hand_q] && dirty_q[hand_q]) begin
            out_wb_o     <= 1'b1;
            out_wb_key_o <= keys_q[hand_q];
            out_wb_val_o <= vals_q[hand_q];
          end
        end
        cwc_pkg::CMD_FLUSH_EMIT: begin
          out_wb_o     <= 1'b1;
          out_wb_key_o <= keys_q[fidx_q];
          out_wb_val_o <= vals_q[fidx_q];
          out_last_o   <= status_o.fmask_last;
        end
        default: ;
      endcase
    end
  end

  // Control: flags, counters, hand, flush walk, config and result valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      ref_q       <= '0;
      dirty_q     <= '0;
      fmask_q     <= '0;
      fidx_q      <= '0;
      filled_q    <= '0;
      hand_q      <= '0;
      cap_q       <= cwc_pkg::CapW'(N);
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) cap_q <= cfg_data_i;
      if (load) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      unique case (cmd_i)
        cwc_pkg::CMD_RESPOND: begin
          if (hit) begin
            ref_q[hit_idx] <= 1'b1;
            if (type_q == cwc_pkg::REQ_SET) dirty_q[hit_idx] <= 1'b1;
          end
        end
        cwc_pkg::CMD_FILL_SLOT, cwc_pkg::CMD_EVICT: begin
          valid_q[slot] <= 1'b1;
          ref_q[slot]   <= 1'b1;
          dirty_q[slot] <= (type_q == cwc_pkg::REQ_SET);
          if (cmd_i == cwc_pkg::CMD_FILL_SLOT) filled_q <= filled_q + cwc_pkg::CntW'(1);
        end
        cwc_pkg::CMD_WRAP: begin
          if (cwc_pkg::CntW'(hand_q) >= cap) hand_q <= '0;
        end
        cwc_pkg::CMD_SWEEP_STEP: begin
          ref_q[hand_q] <= 1'b0;
          hand_q        <= (hand_inc >= cap) ? '0 : hand_inc[cwc_pkg::IdxW-1:0];
        end
        cwc_pkg::CMD_FLUSH_START: begin
          fmask_q <= live_dirty;
          fidx_q  <= '0;
        end
        cwc_pkg::CMD_FLUSH_EMIT: begin
          fmask_q <= fmask_q & ~fidx_bit;
          fidx_q  <= fidx_q + cwc_pkg::IdxW'(1);
        end
        cwc_pkg::CMD_FLUSH_SKIP: begin
          fidx_q <= fidx_q + cwc_pkg::IdxW'(1);
        end
        default: ;
      endcase
    end
  end

  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q <= cwc_pkg::CntW'(N)) else $error("fill count beyond table size");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> out_free) else $error("result register overwritten");

  a_flush_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i == cwc_pkg::CMD_FLUSH_START) |=> (fmask_q != '0))
    else $error("flush walk started with nothing dirty");

  a_hit_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_hit_o && out_wb_o)) else $error("hit with write-back");

endmodule

>>> src/clock_writeback_cache.sv
// Top level of the clock write-back cache: 16-entry fully associative table.
// Depends on cwc_pkg, cwc_ctrl and cwc_datapath.
//
//  channel   direction  handshake                      payload
//  s_axis    in         s_axis_tvalid/s_axis_tready    tuser req_type, tdata key+value
//  m_axis    out        m_axis_tvalid/m_axis_tready    tuser hit+wb_valid, tdata, tlast
//  cfg       in         cfg_valid_i/cfg_ready_o        capacity_in_use
//
// A get, a hit or a miss with a free slot loads its result in the look state once the
// result register is free; the sequencer then returns to idle, where the next item can be taken.
// A miss on a full table wraps the hand, then sweeps it, clearing reference bits, to the victim.
// A flush captures the dirty mask, then walks from slot zero to the last dirty slot.
// A full result register stalls the sequencer; the next item is taken once it is idle.
// Reset clears flags, counters and hand at once; there is no clearing pass.
module clock_writeback_cache (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // req_key[31:0], write_value[63:32]
  input  logic [1:0]  s_axis_tuser,  // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // read_value[31:0], wb_key[63:32], wb_value[95:64]
  output logic [1:0]  m_axis_tuser,  // hit[0], wb_valid[1]
  output logic        m_axis_tlast,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  cwc_pkg::cmd_e    cmd;
  cwc_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  cwc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cwc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .status_o     (status),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_type_i    (s_axis_tuser),
    .in_key_i     (s_axis_tdata[31:0]),
    .in_val_i     (s_axis_tdata[63:32]),
    .out_ready_i  (m_axis_tready),
    .out_valid_o  (m_axis_tvalid),
    .out_hit_o    (m_axis_tuser[0]),
    .out_read_o   (m_axis_tdata[31:0]),
    .out_wb_o     (m_axis_tuser[1]),
    .out_wb_key_o (m_axis_tdata[63:32]),
    .out_wb_val_o (m_axis_tdata[95:64]),
    .out_last_o   (m_axis_tlast)
  );

endmodule

>>> tb/clock_writeback_cache_test.sv
// Self-checking bench for the clock write-back cache top level.
// Drives requests and capacity writes, predicts results with a CLOCK cache model.
// Depends on cwc_pkg and clock_writeback_cache.
module clock_writeback_cache_test;

  typedef struct packed {
    logic                     hit;
    logic [cwc_pkg::ValW-1:0] rd_val;
    logic                     wb_vld;
    logic [cwc_pkg::KeyW-1:0] wb_key;
    logic [cwc_pkg::ValW-1:0] wb_val;
    logic                     last;
  } cache_rsp_t;

  typedef struct {
    cwc_pkg::req_e            op;
    logic [cwc_pkg::KeyW-1:0] key;
    logic [cwc_pkg::ValW-1:0] val;
    logic                     has_rsp;
    cache_rsp_t               rsp;
  } dir_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [63:0]     s_axis_tdata = '0;
  logic [1:0]      s_axis_tuser = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [95:0]     m_axis_tdata;
  logic [1:0]      m_axis_tuser;
  logic            m_axis_tlast;
  logic            cfg_valid_i = 1'b0;
  logic            cfg_ready_o;
  logic [4:0]      cfg_data_i = '0;

  clock_writeback_cache DUT (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // cache mirror
  logic [cwc_pkg::KeyW-1:0] slot_key [cwc_pkg::MaxEntries];
  logic [cwc_pkg::ValW-1:0] slot_val [cwc_pkg::MaxEntries];
  logic            slot_vld [cwc_pkg::MaxEntries];
  logic            slot_ref [cwc_pkg::MaxEntries];
  logic            slot_dty [cwc_pkg::MaxEntries];
  int unsigned     fill_cnt, hand, cap_reg;

  cache_rsp_t      rsp_q [$];
  int              fail_cnt = 0;
  int              cycle_cnt = 0;
  int              src_idle = 23, snk_idle = 57;
  int              recent_key_q [$];

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 2000000) begin
      $display("clock_writeback_cache_test: FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0d: %s", cycle_cnt, what);
    fail_cnt++;
  endtask

  function automatic int unsigned eff_cap();
    if (cap_reg == 0) return 1;
    if (cap_reg > cwc_pkg::MaxEntries) return cwc_pkg::MaxEntries;
    return cap_reg;
  endfunction

  function automatic cache_rsp_t mk_rsp(logic h, logic [cwc_pkg::ValW-1:0] rv, logic w,
                                        logic [cwc_pkg::KeyW-1:0] k,
                                        logic [cwc_pkg::ValW-1:0] v, logic l);
    cache_rsp_t r;
    r.hit = h; r.rd_val = rv; r.wb_vld = w; r.wb_key = k; r.wb_val = v; r.last = l;
    return r;
  endfunction

  // Compute results of one request and advance the mirror.
  task automatic predict_cache(input cwc_pkg::req_e op, input logic [cwc_pkg::KeyW-1:0] key,
                               input logic [cwc_pkg::ValW-1:0] val);
    int unsigned c, slot;
    int idx, n;
    logic wb;
    logic [cwc_pkg::KeyW-1:0] wk;
    logic [cwc_pkg::ValW-1:0] wv;
    c = eff_cap(); idx = -1; n = 0; wb = 0; wk = '0; wv = '0;
    if (op == cwc_pkg::REQ_FLUSH) begin
      for (int i = 0; i < c; i++)
        if (slot_vld[i] && slot_dty[i]) begin
          rsp_q.push_back(mk_rsp(0, '0, 1, slot_key[i], slot_val[i], 0));
          n++;
        end
      if (n == 0) rsp_q.push_back(mk_rsp(0, '0, 0, '0, '0, 1));
      else rsp_q[$].last = 1'b1;
      return;
    end
    for (int i = c - 1; i >= 0; i--)
      if (slot_vld[i] && slot_key[i] == key) idx = i;
    if (idx >= 0) begin
      slot_ref[idx] = 1'b1;
      if (op == cwc_pkg::REQ_SET) begin
        slot_val[idx] = val;
        slot_dty[idx] = 1'b1;
      end
      rsp_q.push_back(mk_rsp(1, op == cwc_pkg::REQ_GET ? slot_val[idx] : '0, 0, '0, '0, 1));
      return;
    end
    if (op == cwc_pkg::REQ_GET) begin
      rsp_q.push_back(mk_rsp(0, '0, 0, '0, '0, 1));
      return;
    end
    if (fill_cnt < c) begin
      slot = fill_cnt;
      fill_cnt++;
    end else begin
      if (hand >= c) hand = 0;
      for (int s = 0; s <= c; s++) begin
        if (!slot_vld[hand] || !slot_ref[hand]) break;
        slot_ref[hand] = 1'b0;
        hand = (hand + 1 >= c) ? 0 : hand + 1;
      end
      slot = hand;
      if (slot_vld[slot] && slot_dty[slot]) begin
        wb = 1; wk = slot_key[slot]; wv = slot_val[slot];
      end
    end
    slot_key[slot] = key; slot_val[slot] = val; slot_vld[slot] = 1'b1;
    slot_ref[slot] = 1'b1; slot_dty[slot] = (op == cwc_pkg::REQ_SET);
    rsp_q.push_back(mk_rsp(0, '0, wb, wk, wv, 1));
  endtask

  // result side
  always @(posedge clk_i) begin
    cache_rsp_t got, exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = mk_rsp(m_axis_tuser[0], m_axis_tdata[31:0], m_axis_tuser[1],
                   m_axis_tdata[63:32], m_axis_tdata[95:64], m_axis_tlast);
      if (rsp_q.size() == 0) report_mismatch("unexpected result");
      else begin
        exp_r = rsp_q.pop_front();
        if (got.hit !== exp_r.hit) report_mismatch("hit");
        if (got.rd_val !== exp_r.rd_val) report_mismatch("read_value");
        if (got.wb_vld !== exp_r.wb_vld) report_mismatch("wb_valid");
        if (got.wb_key !== exp_r.wb_key) report_mismatch("wb_key");
        if (got.wb_val !== exp_r.wb_val) report_mismatch("wb_value");
        if (got.last !== exp_r.last) report_mismatch("last");
      end
    end
    m_axis_tready <= ($urandom_range(99) >= snk_idle);
  end

  // Hold valid high across back-to-back items; drop it only while idling.
  task automatic send_req(input cwc_pkg::req_e op, input logic [cwc_pkg::KeyW-1:0] key,
                          input logic [cwc_pkg::ValW-1:0] val);
    while ($urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {val, key};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_cache(op, key, val);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (rsp_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [4:0] c);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= c;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    cap_reg = c;
  endtask

  function automatic logic [cwc_pkg::KeyW-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom_range(23);
    if (r < 85 && recent_key_q.size() > 0)
      return recent_key_q[$urandom_range(recent_key_q.size() - 1)];
    return $urandom;
  endfunction

  task automatic random_phase(input int n_items);
    cwc_pkg::req_e op;
    logic [cwc_pkg::KeyW-1:0] k;
    int r;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(99);
      op = (r < 30) ? cwc_pkg::REQ_GET : (r < 65) ? cwc_pkg::REQ_SET :
           (r < 93) ? cwc_pkg::REQ_FILL : cwc_pkg::REQ_FLUSH;
      k = pick_key();
      if (k > 23) begin
        recent_key_q.push_back(k);
        if (recent_key_q.size() > 8) void'(recent_key_q.pop_front());
      end
      send_req(op, k, $urandom);
    end
  endtask

  dir_row_t dir_tbl [$];

  task automatic add_row(cwc_pkg::req_e op, logic [cwc_pkg::KeyW-1:0] k,
                         logic [cwc_pkg::ValW-1:0] v, logic chk, cache_rsp_t r);
    dir_row_t row;
    row.op = op; row.key = k; row.val = v; row.has_rsp = chk; row.rsp = r;
    dir_tbl.push_back(row);
  endtask

  initial begin
    cache_rsp_t none;
    none = '0;
    for (int i = 0; i < cwc_pkg::MaxEntries; i++) begin
      slot_key[i] = '0; slot_val[i] = '0;
      slot_vld[i] = 0; slot_ref[i] = 0; slot_dty[i] = 0;
    end
    fill_cnt = 0; hand = 0; cap_reg = cwc_pkg::MaxEntries;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: empty cache, flush of nothing dirty
    add_row(cwc_pkg::REQ_GET,   32'hFFFF_FFFF, 32'h0, 1, mk_rsp(0, '0, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_FLUSH, 32'h0, 32'h0, 1, mk_rsp(0, '0, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
            mk_rsp(0, '0, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_GET,   32'hFFFF_FFFF, 32'h0, 1,
            mk_rsp(1, 32'hFFFF_FFFF, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_FILL,  32'h0, 32'h0, 1, mk_rsp(0, '0, 0, '0, '0, 1));
    // fill of a present key keeps dirty data
    add_row(cwc_pkg::REQ_FILL,  32'hFFFF_FFFF, 32'h1234_5678, 1,
            mk_rsp(1, '0, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_GET,   32'hFFFF_FFFF, 32'h0, 0, none);
    add_row(cwc_pkg::REQ_SET,   32'h0, 32'hA5A5_5A5A, 1, mk_rsp(1, '0, 0, '0, '0, 1));
    add_row(cwc_pkg::REQ_FLUSH, 32'h0, 32'h0, 0, none);
    for (int i = 0; i < 8; i++) add_row(cwc_pkg::REQ_SET, 32'h100 + i, $urandom, 0, none);
    add_row(cwc_pkg::REQ_FLUSH, 32'h0, 32'h0, 0, none);

    src_idle = 23; snk_idle = 57;
    foreach (dir_tbl[i]) begin
      if (dir_tbl[i].has_rsp) begin
        send_req(dir_tbl[i].op, dir_tbl[i].key, dir_tbl[i].val);
        rsp_q[$] = dir_tbl[i].rsp;
      end else
        send_req(dir_tbl[i].op, dir_tbl[i].key, dir_tbl[i].val);
    end

    random_phase(60);
    write_capacity(5'd1);
    random_phase(40);
    src_idle = 57; snk_idle = 23;
    write_capacity(5'd0);
    random_phase(30);
    write_capacity(5'd31);
    random_phase(70);
    write_capacity(5'd4);
    random_phase(60);
    src_idle = 0; snk_idle = 0;
    write_capacity(5'd16);
    random_phase(70);
    write_capacity(5'd10);
    random_phase(60);

    drain_results();
    if (fail_cnt == 0) $display("clock_writeback_cache_test: PASS");
    else $display("clock_writeback_cache_test: FAIL");
    $finish;
  end
endmodule

>>> files.f
src/cwc_pkg.sv
src/cwc_ctrl.sv
src/cwc_datapath.sv
src/clock_writeback_cache.sv
tb/clock_writeback_cache_test.sv
